>>> rtl/core/ast_pkg.sv
package ast_pkg;

  localparam int MaxParticipants = 16;
  localparam int AngleBins       = 360;
  localparam int QueueDepth      = 2;

  localparam int IdW    = $clog2(MaxParticipants + 1);
  localparam int FlagIw = $clog2(MaxParticipants);
  localparam int AngW   = $clog2(AngleBins);
  localparam int QPtrW  = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW  = $clog2(QueueDepth + 1);

  localparam logic [7:0] SpeechClass = 8'h01;

  typedef enum logic [1:0] {
    CFG_THRESHOLD = 2'd0,
    CFG_SPREAD    = 2'd1,
    CFG_LIMIT     = 2'd2
  } ast_cfg_idx_e;

  typedef struct packed {
    logic        frame_start;
    logic [7:0]  category;
    logic [15:0] energy;
    logic [8:0]  angle;
  } ast_in_t;

  typedef struct packed {
    logic [4:0]  participant_id;
    logic        new_participant;
    logic        table_full;
    logic [15:0] talking_mask;
    logic [4:0]  participant_count;
    logic [4:0]  recent_talker;
    logic [31:0] speaking_time;
  } ast_out_t;

  // Classified item as it waits in the queue between front and back.
  typedef struct packed {
    logic            frame_start;
    logic            hit;
    logic [AngW-1:0] angle;
  } ast_job_t;

  typedef struct packed {
    logic pop;
    logic clearing;
  } ast_bstat_t;

endpackage

>>> rtl/core/ast_front.sv
module ast_front
  import ast_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  ast_in_t     item_i,
  input  logic [15:0] threshold_i,
  input  logic        pop_i,
  output logic        job_valid_o,
  output ast_job_t    job_o,
  output logic        full_o
);

  ast_job_t               queue_q [QueueDepth];
  logic     [QPtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic     [QPtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic     [QCntW-1:0]   count_q, count_d;
  ast_job_t               job_new;
  logic                   do_push, do_pop;

  // A source counts only when it is speech, strictly louder than the threshold,
  // and its angle names a real bin.
  always_comb begin
    job_new.frame_start = item_i.frame_start;
    job_new.hit         = (item_i.category == SpeechClass) &&
                          (item_i.energy > threshold_i) &&
                          ({1'b0, item_i.angle} < 10'(AngleBins));
    job_new.angle       = AngW'(item_i.angle);
  end

  assign full_o      = (count_q == QCntW'(QueueDepth));
  assign job_valid_o = (count_q != '0);
  assign job_o       = queue_q[rd_ptr_q];
  assign do_push     = push_i && !full_o;
  assign do_pop      = pop_i && job_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      queue_q[wr_ptr_q] <= job_new;
    end
  end

endmodule

>>> rtl/core/ast_back.sv
module ast_back
  import ast_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       job_valid_i,
  input  ast_job_t   job_i,
  input  logic [7:0] spread_i,
  input  logic [4:0] limit_i,
  output ast_bstat_t stat_o,
  output logic       done_o,
  output ast_out_t   res_o
);

  typedef enum logic [4:0] {
    S_CLEAR  = 5'b00001,
    S_IDLE   = 5'b00010,
    S_DECIDE = 5'b00100,
    S_PAINT  = 5'b01000,
    S_EMIT   = 5'b10000
  } ast_state_e;

  ast_state_e                 state_q, state_d;
  logic       [AngW-1:0]      clr_q, clr_d;
  ast_job_t                   job_q, job_d;
  logic       [IdW-1:0]       pid_q, pid_d;
  logic                       new_q, new_d;
  logic                       full_q, full_d;
  logic       [31:0]          stime_q, stime_d;
  logic       [15:0]          flags_q, flags_d;
  logic       [IdW-1:0]       created_q, created_d;
  logic       [IdW-1:0]       latest_q, latest_d;
  logic       [31:0]          counts_q [MaxParticipants];
  logic       [31:0]          counts_d [MaxParticipants];
  logic       [AngW-1:0]      up_q, up_d, dn_q, dn_d;
  logic       [7:0]           step_q, step_d;
  logic                       phase_q, phase_d;
  logic                       done_q, done_d;
  ast_out_t                   res_q, res_d;

  logic       [IdW-1:0]       map_mem [AngleBins];
  logic       [IdW-1:0]       rdata_q;
  logic                       mem_we;
  logic       [AngW-1:0]      mem_waddr, mem_raddr;
  logic       [IdW-1:0]       mem_wdata;

  logic       [IdW-1:0]       owner, limit, nid;
  logic       [FlagIw-1:0]    cidx;
  logic       [31:0]          cnt_inc;
  logic                       pop;

  assign owner   = rdata_q;
  assign limit   = (limit_i > IdW'(MaxParticipants)) ? IdW'(MaxParticipants) : limit_i;
  assign nid     = created_q + 1'b1;
  assign cidx    = FlagIw'(owner - 1'b1);
  assign cnt_inc = (counts_q[cidx] != '1) ? counts_q[cidx] + 1'b1 : counts_q[cidx];

  always_comb begin
    state_d   = state_q;
    clr_d     = clr_q;
    job_d     = job_q;
    pid_d     = pid_q;
    new_d     = new_q;
    full_d    = full_q;
    stime_d   = stime_q;
    flags_d   = flags_q;
    created_d = created_q;
    latest_d  = latest_q;
    counts_d  = counts_q;
    up_d      = up_q;
    dn_d      = dn_q;
    step_d    = step_q;
    phase_d   = phase_q;
    done_d    = 1'b0;
    res_d     = res_q;
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = clr_q;
    mem_wdata = '0;
    mem_raddr = '0;

    unique case (state_q)
      S_CLEAR: begin
        mem_we = 1'b1;
        if (clr_q == AngW'(AngleBins - 1)) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + 1'b1;
        end
      end
      S_IDLE: begin
        if (job_valid_i) begin
          pop     = 1'b1;
          job_d   = job_i;
          pid_d   = '0;
          new_d   = 1'b0;
          full_d  = 1'b0;
          stime_d = '0;
          if (job_i.frame_start) begin
            flags_d = '0;
          end
          if (job_i.hit) begin
            mem_raddr = job_i.angle;
            state_d   = S_DECIDE;
          end else begin
            state_d = S_EMIT;
          end
        end
      end
      S_DECIDE: begin
        if (owner == '0) begin
          if (created_q >= limit) begin
            full_d  = 1'b1;
            state_d = S_EMIT;
          end else begin
            // A fresh participant has never been counted, so its talk time stays zero.
            created_d                   = nid;
            pid_d                       = nid;
            new_d                       = 1'b1;
            flags_d[FlagIw'(nid - 1'b1)] = 1'b1;
            latest_d                    = nid;
            up_d                        = job_q.angle;
            dn_d                        = job_q.angle;
            step_d                      = '0;
            phase_d                     = 1'b0;
            state_d                     = S_PAINT;
          end
        end else begin
          if (owner <= IdW'(MaxParticipants)) begin
            pid_d           = owner;
            flags_d[cidx]   = 1'b1;
            latest_d        = owner;
            counts_d[cidx]  = cnt_inc;
            stime_d         = cnt_inc;
          end
          state_d = S_EMIT;
        end
      end
      S_PAINT: begin
        // One bin per cycle: the upper side, then the mirrored lower side.
        mem_we    = 1'b1;
        mem_waddr = phase_q ? dn_q : up_q;
        mem_wdata = pid_q;
        if (!phase_q) begin
          phase_d = 1'b1;
        end else begin
          phase_d = 1'b0;
          step_d  = step_q + 1'b1;
          up_d    = (up_q == AngW'(AngleBins - 1)) ? '0 : up_q + 1'b1;
          dn_d    = (dn_q == '0) ? AngW'(AngleBins - 1) : dn_q - 1'b1;
          if (step_q == spread_i) begin
            state_d = S_EMIT;
          end
        end
      end
      S_EMIT: begin
        done_d                  = 1'b1;
        res_d.participant_id    = pid_q;
        res_d.new_participant   = new_q;
        res_d.table_full        = full_q;
        res_d.talking_mask      = flags_q;
        res_d.participant_count = created_q;
        res_d.recent_talker     = latest_q;
        res_d.speaking_time     = stime_q;
        state_d                 = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      flags_q   <= '0;
      created_q <= '0;
      latest_q  <= '0;
      done_q    <= 1'b0;
      for (int i = 0; i < MaxParticipants; i++) begin
        counts_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      flags_q   <= flags_d;
      created_q <= created_d;
      latest_q  <= latest_d;
      done_q    <= done_d;
      counts_q  <= counts_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_q   <= job_d;
    pid_q   <= pid_d;
    new_q   <= new_d;
    full_q  <= full_d;
    stime_q <= stime_d;
    up_q    <= up_d;
    dn_q    <= dn_d;
    step_q  <= step_d;
    phase_q <= phase_d;
    res_q   <= res_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      map_mem[mem_waddr] <= mem_wdata;
    end
    rdata_q <= map_mem[mem_raddr];
  end

  assign stat_o.pop      = pop;
  assign stat_o.clearing = (state_q == S_CLEAR);
  assign done_o          = done_q;
  assign res_o           = res_q;

endmodule

>>> rtl/core/angle_sector_talker_tracker_unit.sv
// Tracks talkers by arrival angle. Sources enter on start while busy is low and
// go through a two-entry queue, so start may be taken while an earlier source is
// still being worked on. Each source yields one result, shown on out_o for exactly
// one cycle while done_o is high; the receiver cannot stall it. The back end goes
// from idle straight to emit for an ignored source, through decide for a known or
// refused talker, and through decide and paint for a new participant, whose bins
// from its angle up and down by sector_spread are painted one bin per cycle. After
// reset all 360 bins of the sector memory are cleared, during which busy is high;
// configuration writes are taken at any time and should be made only while no source is in flight.
module angle_sector_talker_tracker_unit
  import ast_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  ast_in_t     in_i,
  output logic        done_o,
  output ast_out_t    out_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] threshold_q;
  logic [7:0]  spread_q;
  logic [4:0]  limit_q;
  logic        q_full, job_valid;
  ast_job_t    job;
  ast_bstat_t  bstat;

  assign cfg_ready_o = 1'b1;
  assign busy        = q_full || bstat.clearing;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      threshold_q <= '0;
      spread_q    <= '0;
      limit_q     <= 5'd16;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_THRESHOLD: threshold_q <= cfg_data_i;
        CFG_SPREAD:    spread_q    <= cfg_data_i[7:0];
        CFG_LIMIT:     limit_q     <= cfg_data_i[4:0];
        default:       ;
      endcase
    end
  end

  ast_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (start && !busy),
    .item_i      (in_i),
    .threshold_i (threshold_q),
    .pop_i       (bstat.pop),
    .job_valid_o (job_valid),
    .job_o       (job),
    .full_o      (q_full)
  );

  ast_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .job_valid_i (job_valid),
    .job_i       (job),
    .spread_i    (spread_q),
    .limit_i     (limit_q),
    .stat_o      (bstat),
    .done_o      (done_o),
    .res_o       (out_o)
  );

  // Results are spaced apart: the back end returns to idle after every beat.
  a_done_spaced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("two result beats in a row");

  // A newly created participant takes the next id.
  a_new_id: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && out_o.new_participant) |->
      (out_o.participant_id == out_o.participant_count) && !out_o.table_full)
    else $error("new participant id does not match count");

  // A refused or ignored source reports no participant and no talk time.
  a_no_pid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (out_o.participant_id == '0)) |->
      (out_o.speaking_time == '0) && !out_o.new_participant)
    else $error("talk time without a participant");

  // No beat is produced while the sector memory is still being cleared.
  a_clear_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $past(bstat.clearing) |-> !done_o)
    else $error("result during clearing pass");

endmodule
